@@ hdl/sot_pkg.sv @@
// Shared types and constants for the shell operator tokenizer.
// Used by sot_lexer, sot_result_fifo and shell_operator_tokenizer; no dependencies.
package sot_pkg;

  // Token kinds as they appear on the result channel.
  typedef enum logic [3:0] {
    K_WBYTE  = 4'd0,
    K_WEND   = 4'd1,
    K_ANDIF  = 4'd2,
    K_ORIF   = 4'd3,
    K_PIPE   = 4'd4,
    K_SEMI   = 4'd5,
    K_AMP    = 4'd6,
    K_SOPEN  = 4'd7,
    K_SCLOSE = 4'd8,
    K_COPEN  = 4'd9,
    K_CCLOSE = 4'd10,
    K_REDIR  = 4'd11,
    K_ENV    = 4'd12,
    K_FD     = 4'd13,
    K_ERR    = 4'd14
  } kind_e;

  // Redirect directions.
  localparam logic [1:0] RK_IN     = 2'd0;
  localparam logic [1:0] RK_OUT    = 2'd1;
  localparam logic [1:0] RK_INOUT  = 2'd2;
  localparam logic [1:0] RK_APPEND = 2'd3;

  // Lexer modes, one-hot.
  typedef enum logic [2:0] {
    M_IDLE = 3'b001,
    M_WORD = 3'b010,
    M_PEND = 3'b100
  } lex_mode_e;

  // Characters the lexer looks at.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOL   = 8'h24;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BAR   = 8'h7C;

  // At most three results follow from one input byte.
  localparam int RES_MAX   = 3;
  localparam int RES_CNT_W = 2;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] word_char;
    logic [1:0] redirect_kind;
    logic       dup_flag;
    logic [3:0] fd_value;
    logic       last;
  } rec_t;

  typedef rec_t [RES_MAX-1:0] rec_vec_t;

  function automatic rec_t mk_rec(kind_e k, logic [7:0] wc, logic [1:0] rk,
                                  logic dup, logic [3:0] fd);
    rec_t r;
    r.kind          = k;
    r.word_char     = wc;
    r.redirect_kind = rk;
    r.dup_flag      = dup;
    r.fd_value      = fd;
    r.last          = 1'b0;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) || (c == CH_CR) ||
           (c == CH_SPACE) || (c == CH_NUL);
  endfunction

  function automatic logic is_break(logic [7:0] c);
    return (c == CH_AMP) || (c == CH_BAR) || (c == CH_SEMI) || (c == CH_LPAR) ||
           (c == CH_RPAR) || (c == CH_LT) || (c == CH_GT);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_redir_op(logic [7:0] c);
    return (c == CH_LT) || (c == CH_GT) || (c == CH_AMP) || (c == CH_BAR);
  endfunction

endpackage

@@ hdl/shell_operator_tokenizer.sv @@
// Channel   Direction  Ports
// input     in         in_valid, in_stall, in_ch, in_end_of_line
// result    out        out_valid, out_stall, out_kind, out_word_char, out_redirect_kind,
//                      out_dup_flag, out_fd_value, out_last
//
// A byte is lexed straight out of the input register into up to three tokens, which
// enter a four-entry result queue at the edge at which the byte advances; the first
// token is offered once the tokens ahead of it have left. The queue sends one token per
// cycle while out_stall is low, so a byte that makes more tokens takes longer to drain.
// A byte leaves the input register only when the queue, after this cycle's read, has
// room for three tokens, so in_stall follows out_stall within the same cycle.
// Reset clears the input register, the lexer mode, lookahead byte, paren count and the queue.
// Top level of the shell tokenizer; depends on sot_pkg, sot_lexer, sot_result_fifo.
module shell_operator_tokenizer import sot_pkg::*; #(
  parameter int PAREN_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       in_end_of_line,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_kind,
  output logic [7:0] out_word_char,
  output logic [1:0] out_redirect_kind,
  output logic       out_dup_flag,
  output logic [3:0] out_fd_value,
  output logic       out_last
);

  logic                 in_vld_r;
  logic [7:0]           in_ch_r;
  logic                 in_eol_r;
  logic                 room;
  logic                 advance;
  logic                 accept;
  rec_vec_t             recs;
  logic [RES_CNT_W-1:0] n_recs;
  rec_t                 head;

  assign advance  = in_vld_r && room;
  assign in_stall = in_vld_r && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (accept) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_ch_r  <= in_ch;
      in_eol_r <= in_end_of_line;
    end
  end

  sot_lexer #(
    .PAREN_DEPTH(PAREN_DEPTH)
  ) u_lexer (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .ch     (in_ch_r),
    .eol    (in_eol_r),
    .recs   (recs),
    .n_recs (n_recs)
  );

  sot_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (advance),
    .wr_recs  (recs),
    .wr_n     (n_recs),
    .rd_stall (out_stall),
    .rd_valid (out_valid),
    .rd_rec   (head),
    .room     (room)
  );

  assign out_kind          = head.kind;
  assign out_word_char     = head.word_char;
  assign out_redirect_kind = head.redirect_kind;
  assign out_dup_flag      = head.dup_flag;
  assign out_fd_value      = head.fd_value;
  assign out_last          = head.last;

endmodule

@@ hdl/sot_lexer.sv @@
// Lexer core: mode, lookahead byte and paren stack, plus the logic that turns
// one byte into up to three token records. Depends on sot_pkg.
module sot_lexer import sot_pkg::*; #(
  parameter int PAREN_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           ch,
  input  logic                 eol,
  output rec_vec_t             recs,
  output logic [RES_CNT_W-1:0] n_recs
);

  localparam int CW = $clog2(PAREN_DEPTH + 1);

  lex_mode_e              mode_r, mode_nxt;
  logic [7:0]             pend_r, pend_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [PAREN_DEPTH-1:0] stack_r, stack_nxt;
  logic [PAREN_DEPTH:0]   stack_push;

  logic                 do_fresh;
  logic                 push_req;
  logic                 push_bit;
  kind_e                push_tok;
  logic                 pop_req;
  rec_vec_t             r;
  logic [RES_CNT_W-1:0] n;

  assign stack_push = {stack_r, push_bit};

  always_comb begin
    r         = '0;
    n         = '0;
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    stack_nxt = stack_r;
    do_fresh  = 1'b0;
    push_req  = 1'b0;
    push_bit  = 1'b0;
    push_tok  = K_SOPEN;
    pop_req   = 1'b0;

    case (mode_r)
      M_WORD: begin
        if (is_space(ch)) begin
          r[n] = mk_rec(K_WEND, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
          mode_nxt = M_IDLE;
        end else if (is_break(ch)) begin
          r[n] = mk_rec(K_WEND, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
          do_fresh = 1'b1;
        end else begin
          r[n] = mk_rec(K_WBYTE, ch, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
        end
      end
      M_PEND: begin
        mode_nxt = M_IDLE;
        case (pend_r)
          CH_AMP: begin
            if (ch == CH_AMP) begin
              r[n] = mk_rec(K_ANDIF, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
            end else if (ch == CH_GT) begin
              r[n] = mk_rec(K_REDIR, 8'h00, RK_OUT, 1'b1, 4'h0); n = n + 1'b1;
            end else begin
              r[n] = mk_rec(K_AMP, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
              do_fresh = 1'b1;
            end
          end
          CH_BAR: begin
            if (ch == CH_BAR) begin
              r[n] = mk_rec(K_ORIF, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
            end else begin
              r[n] = mk_rec(K_PIPE, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
              do_fresh = 1'b1;
            end
          end
          CH_GT: begin
            if (ch == CH_GT) begin
              r[n] = mk_rec(K_REDIR, 8'h00, RK_APPEND, 1'b0, 4'h0); n = n + 1'b1;
            end else begin
              r[n] = mk_rec(K_REDIR, 8'h00, RK_OUT, 1'b0, 4'h0); n = n + 1'b1;
              do_fresh = 1'b1;
            end
          end
          CH_LT: begin
            if (ch == CH_GT) begin
              r[n] = mk_rec(K_REDIR, 8'h00, RK_INOUT, 1'b0, 4'h0); n = n + 1'b1;
            end else if (ch == CH_AMP) begin
              r[n] = mk_rec(K_REDIR, 8'h00, RK_IN, 1'b1, 4'h0); n = n + 1'b1;
            end else begin
              r[n] = mk_rec(K_REDIR, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
              do_fresh = 1'b1;
            end
          end
          CH_DOL: begin
            if (ch == CH_LPAR) begin
              push_req = 1'b1;
              push_bit = 1'b1;
              push_tok = K_COPEN;
            end else begin
              r[n] = mk_rec(K_ENV, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
              do_fresh = 1'b1;
            end
          end
          default: begin
            // The held byte is a digit.
            if (is_redir_op(ch)) begin
              r[n] = mk_rec(K_FD, 8'h00, RK_IN, 1'b0, pend_r[3:0]); n = n + 1'b1;
              do_fresh = 1'b1;
            end else begin
              r[n] = mk_rec(K_WBYTE, pend_r, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
              if (is_space(ch)) begin
                r[n] = mk_rec(K_WEND, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
              end else if (is_break(ch)) begin
                r[n] = mk_rec(K_WEND, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
                do_fresh = 1'b1;
              end else begin
                r[n] = mk_rec(K_WBYTE, ch, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
                mode_nxt = M_WORD;
              end
            end
          end
        endcase
      end
      default: begin
        do_fresh = 1'b1;
      end
    endcase

    // Start of a new token with the current byte.
    if (do_fresh) begin
      mode_nxt = M_IDLE;
      if (is_space(ch)) begin
        mode_nxt = M_IDLE;
      end else if (ch == CH_SEMI) begin
        r[n] = mk_rec(K_SEMI, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
      end else if (ch == CH_LPAR) begin
        push_req = 1'b1;
        push_bit = 1'b0;
        push_tok = K_SOPEN;
      end else if (ch == CH_RPAR) begin
        pop_req = 1'b1;
      end else if (ch == CH_AMP || ch == CH_BAR || ch == CH_GT || ch == CH_LT ||
                   ch == CH_DOL || is_digit(ch)) begin
        mode_nxt = M_PEND;
        pend_nxt = ch;
      end else begin
        mode_nxt = M_WORD;
        r[n] = mk_rec(K_WBYTE, ch, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
      end
    end

    if (push_req) begin
      if (cnt_r == CW'(PAREN_DEPTH)) begin
        r[n] = mk_rec(K_ERR, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
      end else begin
        r[n] = mk_rec(push_tok, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
        stack_nxt = stack_push[PAREN_DEPTH-1:0];
        cnt_nxt   = cnt_r + CW'(1);
      end
    end

    if (pop_req) begin
      if (cnt_r == '0) begin
        r[n] = mk_rec(K_ERR, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
      end else begin
        if (stack_r[0]) begin
          r[n] = mk_rec(K_CCLOSE, 8'h00, RK_IN, 1'b0, 4'h0);
        end else begin
          r[n] = mk_rec(K_SCLOSE, 8'h00, RK_IN, 1'b0, 4'h0);
        end
        n = n + 1'b1;
        stack_nxt = stack_r >> 1;
        cnt_nxt   = cnt_r - CW'(1);
      end
    end

    // End of line: flush an open word or the held lookahead byte.
    if (eol) begin
      case (mode_nxt)
        M_WORD: begin
          r[n] = mk_rec(K_WEND, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
        end
        M_PEND: begin
          case (pend_nxt)
            CH_AMP: begin
              r[n] = mk_rec(K_AMP, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
            end
            CH_BAR: begin
              r[n] = mk_rec(K_PIPE, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
            end
            CH_GT: begin
              r[n] = mk_rec(K_REDIR, 8'h00, RK_OUT, 1'b0, 4'h0); n = n + 1'b1;
            end
            CH_LT: begin
              r[n] = mk_rec(K_REDIR, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
            end
            CH_DOL: begin
              r[n] = mk_rec(K_ENV, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
            end
            default: begin
              r[n] = mk_rec(K_WBYTE, pend_nxt, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
              r[n] = mk_rec(K_WEND, 8'h00, RK_IN, 1'b0, 4'h0); n = n + 1'b1;
            end
          endcase
        end
        default: begin
          mode_nxt = M_IDLE;
        end
      endcase
      mode_nxt = M_IDLE;
    end

    if (mode_nxt != M_PEND) begin
      pend_nxt = 8'h00;
    end

    if (n != '0) begin
      r[n - 1'b1].last = 1'b1;
    end
  end

  assign recs   = r;
  assign n_recs = n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pend_r <= 8'h00;
      cnt_r  <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Only levels below the count are ever read, so the stack needs no reset.
  always_ff @(posedge clk) begin
    if (step) begin
      stack_r <= stack_nxt;
    end
  end

endmodule

@@ hdl/sot_result_fifo.sv @@
// Four-entry result queue: takes up to three token records per cycle and
// hands out one per cycle while rd_stall is low. Depends on sot_pkg.
module sot_result_fifo import sot_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  rec_vec_t             wr_recs,
  input  logic [RES_CNT_W-1:0] wr_n,
  input  logic                 rd_stall,
  output logic                 rd_valid,
  output rec_t                 rd_rec,
  output logic                 room
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  rec_t            mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] count_r;
  logic            pop;
  logic [CNTW-1:0] wr_add;
  logic [CNTW:0]   free;

  assign rd_valid = (count_r != '0);
  assign rd_rec   = mem_r[rd_ptr_r];
  assign pop      = rd_valid && !rd_stall;
  assign wr_add   = wr_en ? CNTW'(wr_n) : '0;

  // Room means a whole byte's worth of results fits after this cycle's read.
  assign free = (CNTW+1)'(DEPTH) - {1'b0, count_r} + (CNTW+1)'(pop);
  assign room = (free >= (CNTW+1)'(RES_MAX));

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (wr_en && (RES_CNT_W'(i) < wr_n)) begin
        mem_r[wr_ptr_r + PW'(i)] <= wr_recs[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PW'(wr_add);
      rd_ptr_r <= rd_ptr_r + PW'(pop);
      count_r  <= count_r + wr_add - CNTW'(pop);
    end
  end

endmodule
